FILE: rtl/core/pwfr_pkg.sv
// Shared types, constants and register indexes of the pulse width frame receiver.
// Used by every module of the receiver core; it depends on nothing.
package pwfr_pkg;

   localparam int RUN_COUNT_BITS = 8;
   localparam int CFG_CNT_BITS   = 8;
   localparam int CMP_BITS       = (RUN_COUNT_BITS > CFG_CNT_BITS) ? RUN_COUNT_BITS : CFG_CNT_BITS;
   localparam int SAMPLE_BITS    = 10;
   localparam int BYTE_BITS      = 8;
   localparam int LEN_BITS       = 8;
   localparam int KIND_BITS      = 2;
   localparam int PHASE_BITS     = 2;
   localparam int BITCNT_BITS    = 3;

   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANALOG_MODE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANALOG_LOW      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANALOG_HIGH     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ONE_THRESHOLD   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DATA_RUN_LIMIT  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELIM_MIN       = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELIM_MAX       = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_FRAME_BYTES = 3'd7;

   localparam logic [SAMPLE_BITS-1:0]  RST_ANALOG_LOW      = 10'd300;
   localparam logic [SAMPLE_BITS-1:0]  RST_ANALOG_HIGH     = 10'd700;
   localparam logic [CFG_CNT_BITS-1:0] RST_ONE_THRESHOLD   = 8'd3;
   localparam logic [CFG_CNT_BITS-1:0] RST_DATA_RUN_LIMIT  = 8'd11;
   localparam logic [CFG_CNT_BITS-1:0] RST_DELIM_MIN       = 8'd55;
   localparam logic [CFG_CNT_BITS-1:0] RST_DELIM_MAX       = 8'd62;
   localparam logic [LEN_BITS-1:0]     RST_MAX_FRAME_BYTES = 8'd255;

   localparam logic [PHASE_BITS-1:0] PH_IDLE  = 2'd0;
   localparam logic [PHASE_BITS-1:0] PH_ARMED = 2'd1;
   localparam logic [PHASE_BITS-1:0] PH_RECV  = 2'd2;

   localparam logic [KIND_BITS-1:0] EV_BYTE  = 2'd0;
   localparam logic [KIND_BITS-1:0] EV_DONE  = 2'd1;
   localparam logic [KIND_BITS-1:0] EV_ABORT = 2'd2;

   typedef struct packed {
      logic                   digital_level;
      logic [SAMPLE_BITS-1:0] analog_sample;
   } req_payload_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] event_kind;
      logic [BYTE_BITS-1:0] data_byte;
      logic [LEN_BITS-1:0]  frame_length;
   } rsp_payload_type;

   typedef struct packed {
      logic                      level;
      logic [RUN_COUNT_BITS-1:0] count;
   } run_event_type;

   typedef struct packed {
      logic                    analog_mode;
      logic [SAMPLE_BITS-1:0]  analog_low;
      logic [SAMPLE_BITS-1:0]  analog_high;
   } front_cfg_type;

   typedef struct packed {
      logic [CFG_CNT_BITS-1:0] one_threshold;
      logic [CFG_CNT_BITS-1:0] data_run_limit;
      logic [CFG_CNT_BITS-1:0] delim_min;
      logic [CFG_CNT_BITS-1:0] delim_max;
      logic [LEN_BITS-1:0]     max_frame_bytes;
   } back_cfg_type;

endpackage

FILE: rtl/core/pulse_width_frame_receiver_core.sv
// Top level of the pulse width frame receiver core: register file and the three parts.
// Depends on pwfr_pkg, pwfr_front, pwfr_fifo and pwfr_back.
//
// The req channel takes one line sample per beat: a digital level and an analog
// reading, of which analog_mode picks one. The rsp channel gives at most one event per
// sample: a data byte, a delivered frame or an aborted frame, with the frame length.
// The front end measures runs and pushes each finished run into a four-entry queue;
// the decoder pops one run per cycle, unless a stalled rsp holds its beat, and loads
// the rsp output register. A sample that ends a run enters the queue when it is
// accepted, and its event passes from there into the rsp output register.
// Throughput is one sample per cycle while req_stall is low, set by the run counter
// and the decoder step, which each handle an item as it arrives.
// While rsp is stalled the output register holds its beat and the queue fills; once it
// is full, req_stall rises and every sample waits, also one that ends no run.
// Reset is synchronous and clears the run counter, the queue, the frame state and the
// output valid; the registers return to their reset values.
// User must write registers via csr_we, csr_index, csr_wdata only while the block is idle; it does not enforce this.
module pulse_width_frame_receiver_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [pwfr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [pwfr_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  pwfr_pkg::req_payload_type              req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output pwfr_pkg::rsp_payload_type              rsp_payload
);
   import pwfr_pkg::*;

   front_cfg_type front_cfg_ff;
   back_cfg_type  back_cfg_ff;

   logic          run_push;
   run_event_type run_in;
   logic          run_full;
   logic          run_pop;
   run_event_type run_out;
   logic          run_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_cfg_ff.analog_mode    <= 1'b0;
         front_cfg_ff.analog_low     <= RST_ANALOG_LOW;
         front_cfg_ff.analog_high    <= RST_ANALOG_HIGH;
         back_cfg_ff.one_threshold   <= RST_ONE_THRESHOLD;
         back_cfg_ff.data_run_limit  <= RST_DATA_RUN_LIMIT;
         back_cfg_ff.delim_min       <= RST_DELIM_MIN;
         back_cfg_ff.delim_max       <= RST_DELIM_MAX;
         back_cfg_ff.max_frame_bytes <= RST_MAX_FRAME_BYTES;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ANALOG_MODE:     front_cfg_ff.analog_mode    <= csr_wdata[0];
            CSR_ANALOG_LOW:      front_cfg_ff.analog_low     <= csr_wdata;
            CSR_ANALOG_HIGH:     front_cfg_ff.analog_high    <= csr_wdata;
            CSR_ONE_THRESHOLD:   back_cfg_ff.one_threshold   <= csr_wdata[CFG_CNT_BITS-1:0];
            CSR_DATA_RUN_LIMIT:  back_cfg_ff.data_run_limit  <= csr_wdata[CFG_CNT_BITS-1:0];
            CSR_DELIM_MIN:       back_cfg_ff.delim_min       <= csr_wdata[CFG_CNT_BITS-1:0];
            CSR_DELIM_MAX:       back_cfg_ff.delim_max       <= csr_wdata[CFG_CNT_BITS-1:0];
            CSR_MAX_FRAME_BYTES: back_cfg_ff.max_frame_bytes <= csr_wdata[LEN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   pwfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (front_cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .run_push    (run_push),
      .run_event   (run_in),
      .run_full    (run_full)
   );

   pwfr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (run_push),
      .push_data (run_in),
      .full      (run_full),
      .pop       (run_pop),
      .pop_data  (run_out),
      .not_empty (run_ready)
   );

   pwfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (back_cfg_ff),
      .run_ready   (run_ready),
      .run_event   (run_out),
      .run_pop     (run_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/core/pwfr_front.sv
// Front end: turns line samples into levels and times the runs between level changes.
// Depends on pwfr_pkg; each finished run leaves as one beat toward the run queue.
module pwfr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  pwfr_pkg::front_cfg_type   cfg,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  pwfr_pkg::req_payload_type req_payload,
   output logic                      run_push,
   output pwfr_pkg::run_event_type   run_event,
   input  logic                      run_full
);
   import pwfr_pkg::*;

   logic                      prev_level_ff, prev_level_in;
   logic [RUN_COUNT_BITS-1:0] run_count_ff, run_count_in;
   logic                      accept;
   logic                      level;
   logic                      level_ok;

   assign req_stall = run_full;
   assign accept    = req_valid && !run_full;

   always_comb begin
      level    = req_payload.digital_level;
      level_ok = 1'b1;
      if (cfg.analog_mode) begin
         if (req_payload.analog_sample < cfg.analog_low) begin
            level = 1'b0;
         end else if (req_payload.analog_sample > cfg.analog_high) begin
            level = 1'b1;
         end else begin
            level    = 1'b0;
            level_ok = 1'b0;
         end
      end
   end

   always_comb begin
      prev_level_in   = prev_level_ff;
      run_count_in    = run_count_ff;
      run_push        = 1'b0;
      run_event.level = prev_level_ff;
      run_event.count = run_count_ff;
      if (accept && level_ok) begin
         if (level != prev_level_ff) begin
            run_push      = 1'b1;
            prev_level_in = level;
            run_count_in  = '0;
         end else if (run_count_ff != {RUN_COUNT_BITS{1'b1}}) begin
            run_count_in = run_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b0;
         run_count_ff  <= '0;
      end else begin
         prev_level_ff <= prev_level_in;
         run_count_ff  <= run_count_in;
      end
   end

   a_push_clears_count: assert property (@(posedge clock) disable iff (reset)
      run_push |=> run_count_ff == '0)
      else $error("run counter not cleared after a level change");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      run_full |-> !run_push)
      else $error("run pushed into a full queue");

   a_level_follows_push: assert property (@(posedge clock) disable iff (reset)
      run_push |=> prev_level_ff != $past(prev_level_ff))
      else $error("level did not toggle on a finished run");

endmodule

FILE: rtl/core/pwfr_fifo.sv
// Short queue of finished runs between the front end and the frame decoder.
// Depends on pwfr_pkg for the run type and the queue depth.
module pwfr_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pwfr_pkg::run_event_type push_data,
   output logic                    full,
   input  logic                    pop,
   output pwfr_pkg::run_event_type pop_data,
   output logic                    not_empty
);
   import pwfr_pkg::*;

   run_event_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0]   count_ff, count_in;

   assign full      = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? FIFO_PTR_BITS'((32'(wr_ptr_ff) + 1) % FIFO_DEPTH) : wr_ptr_ff;
      rd_ptr_in = pop  ? FIFO_PTR_BITS'((32'(rd_ptr_ff) + 1) % FIFO_DEPTH) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from an empty run queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH))
      else $error("run queue count beyond its depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      FIFO_PTR_BITS'(32'(rd_ptr_ff) + 32'(count_ff)) == wr_ptr_ff)
      else $error("run queue pointers disagree with the count");

endmodule

FILE: rtl/core/pwfr_back.sv
// Frame decoder: classifies each finished run and builds bytes and frame events.
// Depends on pwfr_pkg; it drives the result channel from its own output register.
module pwfr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  pwfr_pkg::back_cfg_type    cfg,
   input  logic                      run_ready,
   input  pwfr_pkg::run_event_type   run_event,
   output logic                      run_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pwfr_pkg::rsp_payload_type rsp_payload
);
   import pwfr_pkg::*;

   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [BYTE_BITS-1:0]   shift_ff, shift_in;
   logic [BITCNT_BITS-1:0] bits_ff, bits_in;
   logic [LEN_BITS-1:0]    bytes_ff, bytes_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_payload_ff, rsp_payload_in;

   logic                   emit;
   rsp_payload_type        result;
   logic [CMP_BITS-1:0]    cnt;
   logic [BYTE_BITS-1:0]   shifted;
   logic                   is_data;
   logic                   is_delim;

   assign run_pop     = run_ready && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      cnt      = CMP_BITS'(run_event.count);
      is_data  = (phase_ff != PH_IDLE) && (cnt < CMP_BITS'(cfg.data_run_limit));
      is_delim = (cnt >= CMP_BITS'(cfg.delim_min)) && (cnt <= CMP_BITS'(cfg.delim_max));
      shifted  = {shift_ff[BYTE_BITS-2:0], (cnt > CMP_BITS'(cfg.one_threshold))};

      phase_in = phase_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      bytes_in = bytes_ff;
      emit     = 1'b0;
      result.event_kind   = EV_BYTE;
      result.data_byte    = '0;
      result.frame_length = bytes_ff;

      if (is_data) begin
         if (phase_ff == PH_ARMED && !run_event.level) begin
            emit              = 1'b1;
            result.event_kind = EV_ABORT;
            phase_in          = PH_IDLE;
            bytes_in          = '0;
            shift_in          = '0;
            bits_in           = '0;
         end else if (bits_ff == {BITCNT_BITS{1'b1}}) begin
            shift_in = '0;
            bits_in  = '0;
            emit     = 1'b1;
            if (bytes_ff >= cfg.max_frame_bytes) begin
               result.event_kind = EV_ABORT;
               phase_in          = PH_IDLE;
               bytes_in          = '0;
            end else begin
               phase_in            = (phase_ff == PH_ARMED) ? PH_RECV : phase_ff;
               bytes_in            = bytes_ff + 1'b1;
               result.event_kind   = EV_BYTE;
               result.data_byte    = shifted;
               result.frame_length = bytes_ff + 1'b1;
            end
         end else begin
            phase_in = (phase_ff == PH_ARMED) ? PH_RECV : phase_ff;
            shift_in = shifted;
            bits_in  = bits_ff + 1'b1;
         end
      end else if (is_delim) begin
         emit     = (phase_ff != PH_IDLE);
         shift_in = '0;
         bits_in  = '0;
         bytes_in = '0;
         if (run_event.level) begin
            result.event_kind = EV_ABORT;
            phase_in          = PH_IDLE;
         end else begin
            result.event_kind = EV_DONE;
            phase_in          = PH_ARMED;
         end
      end else begin
         emit              = (phase_ff != PH_IDLE) && (bytes_ff != '0);
         result.event_kind = EV_DONE;
         phase_in          = PH_IDLE;
         bytes_in          = '0;
         shift_in          = '0;
         bits_in           = '0;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (run_pop && emit) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         shift_ff     <= '0;
         bits_ff      <= '0;
         bytes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (run_pop) begin
            phase_ff <= phase_in;
            shift_ff <= shift_in;
            bits_ff  <= bits_in;
            bytes_ff <= bytes_in;
         end
      end
   end

   a_idle_no_partial: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> bits_ff == '0 && shift_ff == '0)
      else $error("partial byte held while idle");

   a_bytes_only_receiving: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_RECV |-> bytes_ff == '0)
      else $error("byte count held outside a frame being received");

   a_no_pop_while_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !run_pop)
      else $error("run decoded while the result register is blocked");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE || phase_ff == PH_ARMED || phase_ff == PH_RECV)
      else $error("decoder phase out of range");

endmodule

FILE: verif/pulse_width_frame_receiver_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of pulse_width_frame_receiver_core: line sample beats in, frame events out.
// A scoreboard class predicts every event from the accepted beats; depends on pwfr_pkg and the core under test.
module pulse_width_frame_receiver_core_tb;
   import pwfr_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_TAIL  = 16;
   localparam int MAX_REPORTS = 10;
   localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;

   typedef enum int {LINE_LOW, LINE_HIGH, LINE_DEAD} line_kind_type;

   class frame_event_tracker;
      logic                      analog_mode     = 1'b0;
      logic [SAMPLE_BITS-1:0]    analog_low      = RST_ANALOG_LOW;
      logic [SAMPLE_BITS-1:0]    analog_high     = RST_ANALOG_HIGH;
      logic [CFG_CNT_BITS-1:0]   one_threshold   = RST_ONE_THRESHOLD;
      logic [CFG_CNT_BITS-1:0]   data_run_limit  = RST_DATA_RUN_LIMIT;
      logic [CFG_CNT_BITS-1:0]   delim_min       = RST_DELIM_MIN;
      logic [CFG_CNT_BITS-1:0]   delim_max       = RST_DELIM_MAX;
      logic [LEN_BITS-1:0]       max_frame_bytes = RST_MAX_FRAME_BYTES;
      logic                      line_level      = 1'b0;
      logic [RUN_COUNT_BITS-1:0] run_length      = '0;
      logic [PHASE_BITS-1:0]     phase           = PH_IDLE;
      logic [BYTE_BITS-1:0]      shift_byte      = '0;
      int                        bit_count       = 0;
      logic [LEN_BITS-1:0]       byte_count      = '0;
      rsp_payload_type           pending_events[$];
      int                        failures        = 0;
      int                        kind_count[4]   = '{default: 0};

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_ANALOG_MODE:     analog_mode     = val[0];
            CSR_ANALOG_LOW:      analog_low      = val;
            CSR_ANALOG_HIGH:     analog_high     = val;
            CSR_ONE_THRESHOLD:   one_threshold   = val[CFG_CNT_BITS-1:0];
            CSR_DATA_RUN_LIMIT:  data_run_limit  = val[CFG_CNT_BITS-1:0];
            CSR_DELIM_MIN:       delim_min       = val[CFG_CNT_BITS-1:0];
            CSR_DELIM_MAX:       delim_max       = val[CFG_CNT_BITS-1:0];
            CSR_MAX_FRAME_BYTES: max_frame_bytes = val[LEN_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void post_event(logic [KIND_BITS-1:0] kind, logic [BYTE_BITS-1:0] data);
         rsp_payload_type ev;
         ev.event_kind   = kind;
         ev.data_byte    = data;
         ev.frame_length = byte_count;
         pending_events.push_back(ev);
      endfunction

      function void close_frame(logic [KIND_BITS-1:0] kind, bit report);
         if (report) post_event(kind, '0);
         phase      = PH_IDLE;
         byte_count = '0;
         shift_byte = '0;
         bit_count  = 0;
      endfunction

      function void take_sample(req_payload_type beat);
         logic                      level;
         logic                      ended;
         logic [RUN_COUNT_BITS-1:0] length;
         logic [BYTE_BITS-1:0]      done_byte;
         if (analog_mode) begin
            if (beat.analog_sample < analog_low) level = 1'b0;
            else if (beat.analog_sample > analog_high) level = 1'b1;
            else return;
         end else begin
            level = beat.digital_level;
         end
         if (level == line_level) begin
            if (run_length != '1) run_length++;
            return;
         end
         ended      = line_level;
         length     = run_length;
         line_level = level;
         run_length = '0;
         if (phase != PH_IDLE && length < data_run_limit) begin
            if (phase == PH_ARMED) begin
               if (!ended) begin
                  close_frame(EV_ABORT, 1'b1);
                  return;
               end
               phase = PH_RECV;
            end
            shift_byte = {shift_byte[BYTE_BITS-2:0], length > one_threshold};
            bit_count++;
            if (bit_count < BYTE_BITS) return;
            done_byte  = shift_byte;
            shift_byte = '0;
            bit_count  = 0;
            if (byte_count >= max_frame_bytes) begin
               close_frame(EV_ABORT, 1'b1);
               return;
            end
            byte_count++;
            post_event(EV_BYTE, done_byte);
         end else if (length >= delim_min && length <= delim_max) begin
            if (ended) begin
               close_frame(EV_ABORT, phase != PH_IDLE);
               return;
            end
            if (phase != PH_IDLE) post_event(EV_DONE, '0);
            close_frame(EV_DONE, 1'b0);
            phase = PH_ARMED;
         end else begin
            close_frame(EV_DONE, phase != PH_IDLE && byte_count != 0);
         end
      endfunction

      function void match_event(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_events.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("ERROR %0t: unexpected event kind=%0d byte=%02h length=%0d",
                        $time, got.event_kind, got.data_byte, got.frame_length);
            return;
         end
         want = pending_events.pop_front();
         kind_count[want.event_kind]++;
         if (got.event_kind !== want.event_kind || got.data_byte !== want.data_byte ||
             got.frame_length !== want.frame_length) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("ERROR %0t: expected kind=%0d byte=%02h length=%0d, got kind=%0d byte=%02h length=%0d",
                        $time, want.event_kind, want.data_byte, want.frame_length,
                        got.event_kind, got.data_byte, got.frame_length);
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   logic                      req_valid;
   logic                      req_stall;
   req_payload_type           req_payload;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_payload_type           rsp_payload;

   frame_event_tracker tracker;
   int   snd_idle_pct  = 0;
   int   rcv_idle_pct  = 0;
   int   quiet_cycles  = 0;
   int   samples_sent  = 0;
   int   dead_sent     = 0;
   int   settings_used = 0;
   logic line_now      = 1'b0;

   pulse_width_frame_receiver_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99, 0) < rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.match_event(rsp_payload);
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic req_payload_type make_sample(line_kind_type kind);
      req_payload_type beat;
      int              lo;
      int              hi;
      lo = tracker.analog_low;
      hi = tracker.analog_high;
      beat.digital_level = 1'($urandom_range(1, 0));
      beat.analog_sample = SAMPLE_BITS'($urandom_range(SAMPLE_MAX, 0));
      if (!tracker.analog_mode) begin
         beat.digital_level = (kind == LINE_HIGH);
      end else if (kind == LINE_LOW) begin
         beat.analog_sample = SAMPLE_BITS'($urandom_range(lo - 1, 0));
      end else if (kind == LINE_HIGH) begin
         beat.analog_sample =
            SAMPLE_BITS'($urandom_range(SAMPLE_MAX, (hi + 1 > lo) ? hi + 1 : lo));
      end else begin
         beat.analog_sample = SAMPLE_BITS'($urandom_range(hi, lo));
      end
      return beat;
   endfunction

   function automatic int noise_length();
      int limit;
      limit = tracker.data_run_limit;
      return $urandom_range((limit < 16) ? limit + 4 : 12, 0);
   endfunction

   function automatic int delim_length();
      int lo;
      int hi;
      lo = tracker.delim_min;
      hi = tracker.delim_max;
      if ($urandom_range(3, 0) == 0) return hi;
      return $urandom_range((lo + 6 < hi) ? lo + 6 : hi, lo);
   endfunction

   task automatic drive_beat(req_payload_type beat);
      while ($urandom_range(99, 0) < snd_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = beat;
      do @(posedge clock); while (req_stall);
      tracker.take_sample(beat);
      @(negedge clock);
   endtask

   task automatic send_run(int length);
      logic level;
      level = !line_now;
      repeat (length + 1) begin
         if (tracker.analog_mode && tracker.analog_low <= tracker.analog_high &&
             $urandom_range(9, 0) == 0) begin
            drive_beat(make_sample(LINE_DEAD));
            dead_sent++;
         end
         drive_beat(make_sample(level ? LINE_HIGH : LINE_LOW));
         samples_sent++;
      end
      line_now = level;
   endtask

   task automatic send_frame();
      int limit;
      int zero_top;
      int one_lo;
      int one_top;
      int bits;
      limit    = tracker.data_run_limit;
      zero_top = (tracker.one_threshold < limit - 1) ? tracker.one_threshold : limit - 1;
      if (zero_top > 6) zero_top = 6;
      one_lo   = tracker.one_threshold + 1;
      one_top  = (one_lo + 5 < limit - 1) ? one_lo + 5 : limit - 1;
      if (line_now == 1'b0) send_run(noise_length());
      send_run(delim_length());
      bits = 8 * $urandom_range(4, 0);
      if ($urandom_range(1, 0)) bits += $urandom_range(7, 1);
      repeat (bits) begin
         if ($urandom_range(1, 0) && one_lo <= one_top) send_run($urandom_range(one_top, one_lo));
         else send_run($urandom_range(zero_top, 0));
      end
      case ($urandom_range(3, 0))
         0, 1: send_run($urandom_range(limit + 12, limit));
         2: send_run(delim_length());
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (tracker.pending_events.size() != 0) @(negedge clock);
      repeat (DRAIN_TAIL) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, int val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val[CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_we    = 1'b0;
      tracker.set_reg(idx, val[CSR_DATA_BITS-1:0]);
   endtask

   task automatic apply_setting(int mode, int low, int high, int thresh, int limit,
                                int dmin, int dmax, int fmax);
      drain();
      write_reg(CSR_ANALOG_MODE, mode);
      write_reg(CSR_ANALOG_LOW, low);
      write_reg(CSR_ANALOG_HIGH, high);
      write_reg(CSR_ONE_THRESHOLD, thresh);
      write_reg(CSR_DATA_RUN_LIMIT, limit);
      write_reg(CSR_DELIM_MIN, dmin);
      write_reg(CSR_DELIM_MAX, dmax);
      write_reg(CSR_MAX_FRAME_BYTES, fmax);
      settings_used++;
   endtask

   task automatic run_random(int count);
      int goal;
      goal = samples_sent + count;
      while (samples_sent < goal) begin
         if ($urandom_range(99, 0) < 15) begin
            repeat ($urandom_range(4, 1)) send_run(noise_length());
         end else begin
            send_frame();
         end
         if ($urandom_range(19, 0) == 0) drain();
      end
   endtask

   initial begin
      tracker     = new();
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      snd_idle_pct = 23;
      rcv_idle_pct = 79;
      // A byte of all ones, then a byte of zeros that overflows a one-byte frame.
      apply_setting(0, 300, 700, 0, 2, 2, 3, 1);
      send_run(1);
      send_run(2);
      repeat (8) send_run(1);
      repeat (8) send_run(0);
      send_run(2);
      apply_setting(0, 300, 700, 1, 4, 5, 7, 3);
      run_random(450);
      apply_setting(1, 200, 800, 2, 5, 6, 8, 255);
      run_random(400);

      drain();
      snd_idle_pct = 79;
      rcv_idle_pct = 23;
      apply_setting(1, 900, 100, 0, 3, 3, 4, 0);
      run_random(250);
      apply_setting(0, 0, SAMPLE_MAX, 255, 255, 0, 255, 255);
      run_random(300);
      apply_setting(1, 0, SAMPLE_MAX, 255, 255, 0, 255, 255);
      repeat (12) begin
         drive_beat(make_sample(LINE_DEAD));
         dead_sent++;
      end
      apply_setting(1, SAMPLE_MAX, 0, 0, 1, 1, 3, 1);
      run_random(200);

      drain();
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      apply_setting(0, 300, 700, 3, 11, 55, 62, 255);
      run_random(350);
      drain();

      $display("Run covered %0d line samples and %0d dead-zone samples over %0d register settings.",
               samples_sent, dead_sent, settings_used);
      $display("Checked %0d data bytes, %0d delivered frames and %0d aborted frames; %0d failures.",
               tracker.kind_count[EV_BYTE], tracker.kind_count[EV_DONE],
               tracker.kind_count[EV_ABORT], tracker.failures);
      if (tracker.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

FILE: sim.f
rtl/core/pwfr_pkg.sv
rtl/core/pwfr_front.sv
rtl/core/pwfr_fifo.sv
rtl/core/pwfr_back.sv
rtl/core/pulse_width_frame_receiver_core.sv
verif/pulse_width_frame_receiver_core_tb.sv
